// ----- rtl/ps2_scd_pkg.sv -----
// ps2_scd_pkg: types, byte codes and keymap rom shared by the set-2 decoder
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package ps2_scd_pkg;

  localparam int SKIP_W = 3;

  localparam logic [7:0] CODE_EXTEND  = 8'hE0;
  localparam logic [7:0] CODE_RELEASE = 8'hF0;
  localparam logic [7:0] CODE_PAUSE   = 8'hE1;
  localparam logic [7:0] CODE_BAT_OK  = 8'hAA;
  localparam logic [7:0] CODE_ERROR   = 8'hFF;
  localparam logic [7:0] EXT_BIT      = 8'h80;
  localparam logic [7:0] CODE_LSHIFT  = 8'h12;
  localparam logic [7:0] CODE_RSHIFT  = 8'h59;
  localparam logic [7:0] CODE_LCTRL   = 8'h14;
  localparam logic [7:0] CODE_RCTRL   = 8'h94;
  localparam logic [7:0] CODE_LALT    = 8'h11;
  localparam logic [7:0] CODE_RALT    = 8'h91;
  localparam logic [7:0] CODE_CAPS    = 8'h58;

  localparam logic [7:0] CTRL_MASK = 8'h1F;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // config register indexes
  localparam logic REG_RAW_MODE = 1'b0;

  // one decoded event waiting for translation
  typedef struct packed {
    logic       rel;
    logic [7:0] code;
    logic       shift;
    logic       ctrl;
    logic       alt;
    logic       caps;
  } scd_event_t;

  // keymap: lower half plain, upper half shifted / extended
  localparam logic [7:0] KEY_TABLE [256] = '{
    8'h00, 8'hF9, 8'h00, 8'hF5, 8'hF3, 8'hF1, 8'hF2, 8'hFC,
    8'h00, 8'hFA, 8'hF8, 8'hF6, 8'hF4, 8'h09, 8'h60, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
    8'h00, 8'h00, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
    8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
    8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
    8'h00, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h00,
    8'h00, 8'h00, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'h00,
    8'h00, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'h00,
    8'h00, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'h00,
    8'h00, 8'h00, 8'h27, 8'h00, 8'h5B, 8'h3D, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h0D, 8'h5D, 8'h00, 8'h23, 8'h00, 8'h00,
    8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
    8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1B, 8'h00,
    8'hFB, 8'h2B, 8'h33, 8'h2D, 8'h2A, 8'h39, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'hF7, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h51, 8'h21, 8'h00,
    8'h00, 8'h00, 8'h5A, 8'h53, 8'h41, 8'h57, 8'h22, 8'h00,
    8'h00, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'hA3, 8'h00,
    8'h00, 8'h00, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'h00,
    8'h00, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h59, 8'h5E, 8'h00,
    8'h00, 8'h00, 8'h4D, 8'h4A, 8'h55, 8'h26, 8'h2A, 8'h00,
    8'h00, 8'h3C, 8'h4B, 8'h49, 8'h4F, 8'h29, 8'h28, 8'h00,
    8'h00, 8'h3E, 8'h2F, 8'h4C, 8'h3A, 8'h50, 8'h5F, 8'h00,
    8'h00, 8'h00, 8'h40, 8'h00, 8'h7B, 8'h2B, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h0D, 8'h7D, 8'h00, 8'h7E, 8'h00, 8'h00,
    8'h00, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h85, 8'h00, 8'h82, 8'h84, 8'h00, 8'h00, 8'h00,
    8'h86, 8'h7F, 8'h81, 8'h00, 8'h83, 8'h80, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h88, 8'h00, 8'h00, 8'h87, 8'h00, 8'h00
  };

endpackage

`default_nettype wire

// ----- rtl/ps2_scd_byte_if.sv -----
// ps2_scd_byte_if: valid/ready channel carrying one received keyboard byte
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ps2_scd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/ps2_scd_key_if.sv -----
// ps2_scd_key_if: valid/ready channel carrying one decoded key event
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ps2_scd_key_if;
  logic       valid;
  logic       ready;
  logic       is_release;
  logic [7:0] ext_code;
  logic [7:0] key_char;
  logic       shift_held;
  logic       ctrl_held;
  logic       alt_held;

  modport source (
    output valid, output is_release, output ext_code, output key_char,
    output shift_held, output ctrl_held, output alt_held, input ready
  );
  modport sink (
    input valid, input is_release, input ext_code, input key_char,
    input shift_held, input ctrl_held, input alt_held, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/ps2_scd_front.sv -----
// ps2_scd_front: prefix, pause and modifier tracking; turns bytes into key events
// depends on ps2_scd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2_scd_front
  import ps2_scd_pkg::*;
#(
  parameter int PAUSE_SKIP = 7
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       raw_mode,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_data,
  input  wire logic       room,
  output logic            byte_ready,
  output logic            push,
  output scd_event_t      push_event
);

  logic              release_pending, release_pending_next;
  logic              extend_pending, extend_pending_next;
  logic [SKIP_W-1:0] skip_left, skip_left_next;
  logic [1:0]        shift_bits, shift_bits_next;
  logic [1:0]        ctrl_bits, ctrl_bits_next;
  logic [1:0]        alt_bits, alt_bits_next;
  logic              caps_on, caps_on_next;
  logic              accept;
  logic [7:0]        code;
  logic              press;

  assign byte_ready = room;
  assign accept     = byte_valid && room;
  assign code       = extend_pending ? (byte_data | EXT_BIT) : byte_data;
  assign press      = !release_pending;

  always_comb begin
    release_pending_next = release_pending;
    extend_pending_next  = extend_pending;
    skip_left_next       = skip_left;
    shift_bits_next      = shift_bits;
    ctrl_bits_next       = ctrl_bits;
    alt_bits_next        = alt_bits;
    caps_on_next         = caps_on;
    push                 = 1'b0;
    if (accept) begin
      if (skip_left != '0) begin
        skip_left_next = skip_left - 1'b1;
      end else if (byte_data == CODE_EXTEND) begin
        extend_pending_next = 1'b1;
      end else if (byte_data == CODE_RELEASE) begin
        release_pending_next = 1'b1;
      end else begin
        release_pending_next = 1'b0;
        extend_pending_next  = 1'b0;
        if (byte_data == CODE_PAUSE) begin
          skip_left_next = SKIP_W'(PAUSE_SKIP);
        end else if (byte_data != CODE_BAT_OK && byte_data != CODE_ERROR) begin
          // press sets the modifier bit, release clears it
          if (code == CODE_LSHIFT) shift_bits_next[0] = press;
          if (code == CODE_RSHIFT) shift_bits_next[1] = press;
          if (code == CODE_LCTRL)  ctrl_bits_next[0]  = press;
          if (code == CODE_RCTRL)  ctrl_bits_next[1]  = press;
          if (code == CODE_LALT)   alt_bits_next[0]   = press;
          if (code == CODE_RALT)   alt_bits_next[1]   = press;
          if (!press) begin
            push = raw_mode;
          end else if (code == CODE_CAPS) begin
            caps_on_next = !caps_on;
          end else begin
            push = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    push_event.rel   = release_pending;
    push_event.code  = code;
    push_event.shift = shift_bits_next != '0;
    push_event.ctrl  = ctrl_bits_next != '0;
    push_event.alt   = alt_bits_next != '0;
    push_event.caps  = caps_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_pending <= 1'b0;
      extend_pending  <= 1'b0;
      skip_left       <= '0;
      shift_bits      <= '0;
      ctrl_bits       <= '0;
      alt_bits        <= '0;
      caps_on         <= 1'b0;
    end else begin
      release_pending <= release_pending_next;
      extend_pending  <= extend_pending_next;
      skip_left       <= skip_left_next;
      shift_bits      <= shift_bits_next;
      ctrl_bits       <= ctrl_bits_next;
      alt_bits        <= alt_bits_next;
      caps_on         <= caps_on_next;
    end
  end

`ifndef SYNTHESIS
  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    skip_left <= SKIP_W'(PAUSE_SKIP))
    else $error("pause skip count above its load value");

  a_skip_swallows: assert property (@(posedge clk) disable iff (rst)
    (accept && skip_left != '0) |-> !push)
    else $error("event produced while skipping a pause sequence");

  a_pause_loads: assert property (@(posedge clk) disable iff (rst)
    (accept && skip_left == '0 && byte_data == CODE_PAUSE)
      |=> (skip_left == SKIP_W'(PAUSE_SKIP) && !release_pending && !extend_pending))
    else $error("pause prefix did not load the skip count");
`endif

endmodule

`default_nettype wire

// ----- rtl/ps2_scd_queue.sv -----
// ps2_scd_queue: short fifo of key events between front and back
// depends on ps2_scd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2_scd_queue
  import ps2_scd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire scd_event_t  push_event,
  output logic             room,
  input  wire logic        pop,
  output logic             head_valid,
  output scd_event_t       head_event
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  scd_event_t         mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign room       = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_event = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (room || pop))
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("event queue underflow");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("event queue count did not follow a push");
`endif

endmodule

`default_nettype wire

// ----- rtl/ps2_scd_back.sv -----
// ps2_scd_back: keymap lookup, shift/ctrl/caps translation and output register
// depends on ps2_scd_pkg, ps2_scd_key_if
`timescale 1ns / 1ps
`default_nettype none

module ps2_scd_back
  import ps2_scd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire scd_event_t head_event,
  output logic            pop,
  ps2_scd_key_if.source   keys
);

  logic       out_valid;
  logic [7:0] plain_key;
  logic [7:0] shifted_key;
  logic [7:0] key_sel;
  logic [7:0] key_ctrl;
  logic [7:0] key_final;
  logic       letter;
  logic       emit;

  assign pop = head_valid && (!out_valid || keys.ready);

  always_comb begin
    plain_key   = KEY_TABLE[head_event.code];
    shifted_key = KEY_TABLE[{1'b1, head_event.code[6:0]}];
    if (head_event.shift && !head_event.code[7] && shifted_key != '0) begin
      key_sel = shifted_key;
    end else begin
      key_sel = plain_key;
    end
    key_ctrl = head_event.ctrl ? (key_sel & CTRL_MASK) : key_sel;
    letter   = (key_ctrl >= 8'h41 && key_ctrl <= 8'h5A)
               || (key_ctrl >= 8'h61 && key_ctrl <= 8'h7A);
    key_final = (head_event.caps && letter) ? (key_ctrl ^ CASE_BIT) : key_ctrl;
    // releases always report, presses with an empty mapping are dropped
    emit = head_event.rel || (key_final != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (keys.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      keys.is_release <= head_event.rel;
      keys.ext_code   <= head_event.code;
      keys.key_char   <= head_event.rel ? 8'h00 : key_final;
      keys.shift_held <= head_event.shift;
      keys.ctrl_held  <= head_event.ctrl;
      keys.alt_held   <= head_event.alt;
    end
  end

  assign keys.valid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/ps2_scd_core.sv -----
// ps2_set2_scancode_decoder_core: top level with apb register, front, queue and back
// depends on ps2_scd_pkg, ps2_scd_byte_if, ps2_scd_key_if and the ps2_scd modules
`timescale 1ns / 1ps
`default_nettype none

// PS/2 scan code set 2 decoder. Takes one keyboard byte per cycle while the event queue
// has room; a byte that produces a key event is classified by the front into the event
// queue at the accepting edge, and from the queue the back takes it through keymap lookup
// into the output register. The event queue of QUEUE_DEPTH entries lets the byte side
// keep going while the output is stalled; bytes are held back only once it is full.
// Prefix bytes, the bytes of a Pause sequence, AA, FF and caps lock presses produce
// nothing, and releases are reported only with raw_mode set (register 0 at
// byte address 0). Change the mode only while no byte is in flight.
module ps2_set2_scancode_decoder_core
  import ps2_scd_pkg::*;
#(
  parameter int PAUSE_SKIP  = 7,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  ps2_scd_byte_if.sink     scan,
  ps2_scd_key_if.source    keys
);

  logic       raw_mode;
  logic       reg_write;
  logic       room;
  logic       push;
  logic       pop;
  logic       head_valid;
  scd_event_t push_event;
  scd_event_t head_event;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && (paddr[2] == REG_RAW_MODE);
  assign prdata    = (paddr[2] == REG_RAW_MODE) ? {31'b0, raw_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
    end else if (reg_write) begin
      raw_mode <= pwdata[0];
    end
  end

  ps2_scd_front #(
    .PAUSE_SKIP (PAUSE_SKIP)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .raw_mode   (raw_mode),
    .byte_valid (scan.valid),
    .byte_data  (scan.scan_byte),
    .room       (room),
    .byte_ready (scan.ready),
    .push       (push),
    .push_event (push_event)
  );

  ps2_scd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head_event (head_event)
  );

  ps2_scd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_event (head_event),
    .pop        (pop),
    .keys       (keys)
  );

endmodule

`default_nettype wire
